[sv/mgr_pkg.sv]
// Shared types and constants for the multisample gamma resolve block.
package mgr_pkg;

    localparam int NUM_CH      = 3;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 24;
    localparam int SPP_W       = 9;
    localparam int PIX_W       = 8;
    localparam int QUO_W       = SUM_W + 1;
    localparam int RAD_W       = 2 * PIX_W;
    localparam int SREM_W      = PIX_W + 1;
    localparam int STEP_W      = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = PTR_W + 1;

    localparam logic [SPP_W-1:0] SPP_RESET = 9'd5;

    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        sum_t [NUM_CH-1:0] sum;
        logic [SPP_W-1:0]  n;
    } job_t;

endpackage

[sv/mgr_front.sv]
// Front end: configuration register, per-pixel channel accumulation and job issue.
module mgr_front #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [mgr_pkg::SPP_W-1:0]     cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [mgr_pkg::SAMPLE_W-1:0]  red_sample,
    input  logic [mgr_pkg::SAMPLE_W-1:0]  green_sample,
    input  logic [mgr_pkg::SAMPLE_W-1:0]  blue_sample,
    input  logic                          job_full,
    output logic                          job_push,
    output mgr_pkg::job_t                 job
);

    logic [mgr_pkg::SPP_W-1:0]                             spp_reg;
    logic [mgr_pkg::SPP_W-1:0]                             count_reg;
    logic [mgr_pkg::SPP_W-1:0]                             count_next;
    mgr_pkg::sum_t [mgr_pkg::NUM_CH-1:0]                   sum_reg;
    mgr_pkg::sum_t [mgr_pkg::NUM_CH-1:0]                   sum_next;
    mgr_pkg::sum_t [mgr_pkg::NUM_CH-1:0]                   sum_add;
    logic [mgr_pkg::NUM_CH-1:0][mgr_pkg::SAMPLE_W-1:0]     samples;
    logic [mgr_pkg::SUM_W:0]                               wide;
    logic [mgr_pkg::SPP_W:0]                               count_inc;
    logic [mgr_pkg::SPP_W-1:0]                             n_eff;
    logic                                                  accept;
    logic                                                  complete;

    always_comb
    begin
        samples[0] = red_sample;
        samples[1] = green_sample;
        samples[2] = blue_sample;

        if (spp_reg == '0)
        begin
            n_eff = mgr_pkg::SPP_W'(1);
        end
        else if (int'(spp_reg) > MAX_SAMPLES)
        begin
            n_eff = mgr_pkg::SPP_W'(MAX_SAMPLES);
        end
        else
        begin
            n_eff = spp_reg;
        end

        accept    = push && !job_full;
        count_inc = {1'b0, count_reg} + (mgr_pkg::SPP_W + 1)'(1);
        complete  = count_inc >= {1'b0, n_eff};

        wide = '0;
        for (int ch = 0; ch < mgr_pkg::NUM_CH; ch++)
        begin
            wide = {1'b0, sum_reg[ch]} + (mgr_pkg::SUM_W + 1)'(samples[ch]);
            sum_add[ch] = wide[mgr_pkg::SUM_W] ? '1 : wide[mgr_pkg::SUM_W-1:0];
        end

        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (complete)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_inc[mgr_pkg::SPP_W-1:0];
            end
        end

        full     = job_full;
        job_push = accept && complete;
        job.sum  = sum_add;
        job.n    = n_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg   <= mgr_pkg::SPP_RESET;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                spp_reg <= cfg_data;
            end
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

[sv/mgr_queue.sv]
// Short job queue between the accumulating front end and the resolving back end.
module mgr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mgr_pkg::job_t job_in,
    output logic          full,
    input  logic          pop,
    output mgr_pkg::job_t job_out,
    output logic          empty
);

    mgr_pkg::job_t                    entries [mgr_pkg::QUEUE_DEPTH];
    logic [mgr_pkg::PTR_W-1:0]        wr_ptr_reg;
    logic [mgr_pkg::PTR_W-1:0]        rd_ptr_reg;
    logic [mgr_pkg::CNT_W-1:0]        count_reg;
    logic                             do_push;
    logic                             do_pop;

    always_comb
    begin
        full    = count_reg == mgr_pkg::CNT_W'(mgr_pkg::QUEUE_DEPTH);
        empty   = count_reg == '0;
        do_push = push && !full;
        do_pop  = pop && !empty;
        job_out = entries[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + mgr_pkg::PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + mgr_pkg::PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + mgr_pkg::CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - mgr_pkg::CNT_W'(1);
            end
        end
    end

endmodule

[sv/mgr_back.sv]
// Back end: bit-serial divide by the sample count, bit-serial square root and result register.
module mgr_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_empty,
    input  mgr_pkg::job_t              job,
    output logic                       job_pop,
    input  logic                       pop,
    output logic                       empty,
    output logic [mgr_pkg::PIX_W-1:0]  red_out,
    output logic [mgr_pkg::PIX_W-1:0]  green_out,
    output logic [mgr_pkg::PIX_W-1:0]  blue_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_WRITE
    } state_t;

    state_t                                              state_reg, state_next;
    logic [mgr_pkg::STEP_W-1:0]                          step_reg, step_next;
    logic [mgr_pkg::SPP_W-1:0]                           n_reg, n_next;
    logic [mgr_pkg::NUM_CH-1:0][mgr_pkg::QUO_W-1:0]      quo_reg, quo_next;
    logic [mgr_pkg::NUM_CH-1:0][mgr_pkg::SPP_W-1:0]      rem_reg, rem_next;
    logic [mgr_pkg::NUM_CH-1:0][mgr_pkg::RAD_W-1:0]      rad_reg, rad_next;
    logic [mgr_pkg::NUM_CH-1:0][mgr_pkg::SREM_W-1:0]     srem_reg, srem_next;
    logic [mgr_pkg::NUM_CH-1:0][mgr_pkg::PIX_W-1:0]      root_reg, root_next;
    logic [mgr_pkg::NUM_CH-1:0]                          sat_reg, sat_next;
    logic [mgr_pkg::NUM_CH-1:0][mgr_pkg::PIX_W-1:0]      out_reg, out_next;
    logic                                                out_valid_reg, out_valid_next;
    logic [mgr_pkg::SPP_W:0]                             div_trial;
    logic [mgr_pkg::SREM_W+1:0]                          sq_shift;
    logic [mgr_pkg::SREM_W+1:0]                          sq_trial;
    logic                                                qbit;
    logic [mgr_pkg::QUO_W-1:0]                           quo_new;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        sat_next       = sat_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_trial      = '0;
        sq_shift       = '0;
        sq_trial       = '0;
        qbit           = 1'b0;
        quo_new        = '0;
        job_pop        = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop   = 1'b1;
                    n_next    = job.n;
                    rem_next  = '0;
                    step_next = mgr_pkg::STEP_W'(mgr_pkg::QUO_W - 1);
                    for (int ch = 0; ch < mgr_pkg::NUM_CH; ch++)
                    begin
                        quo_next[ch] = {job.sum[ch], 1'b0};
                    end
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                for (int ch = 0; ch < mgr_pkg::NUM_CH; ch++)
                begin
                    div_trial = {rem_reg[ch], quo_reg[ch][mgr_pkg::QUO_W-1]};
                    qbit      = div_trial >= {1'b0, n_reg};
                    if (qbit)
                    begin
                        rem_next[ch] = mgr_pkg::SPP_W'(div_trial - {1'b0, n_reg});
                    end
                    else
                    begin
                        rem_next[ch] = div_trial[mgr_pkg::SPP_W-1:0];
                    end
                    quo_new      = {quo_reg[ch][mgr_pkg::QUO_W-2:0], qbit};
                    quo_next[ch] = quo_new;
                    rad_next[ch] = quo_new[mgr_pkg::RAD_W-1:0];
                    sat_next[ch] = |quo_new[mgr_pkg::QUO_W-1:mgr_pkg::RAD_W];
                end
                srem_next = '0;
                root_next = '0;
                if (step_reg == '0)
                begin
                    step_next  = mgr_pkg::STEP_W'(mgr_pkg::PIX_W - 1);
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg - mgr_pkg::STEP_W'(1);
                end
            end

            ST_SQRT:
            begin
                for (int ch = 0; ch < mgr_pkg::NUM_CH; ch++)
                begin
                    sq_shift = {srem_reg[ch], rad_reg[ch][mgr_pkg::RAD_W-1 -: 2]};
                    sq_trial = {1'b0, root_reg[ch], 2'b01};
                    if (sq_shift >= sq_trial)
                    begin
                        srem_next[ch] = mgr_pkg::SREM_W'(sq_shift - sq_trial);
                        root_next[ch] = {root_reg[ch][mgr_pkg::PIX_W-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_next[ch] = sq_shift[mgr_pkg::SREM_W-1:0];
                        root_next[ch] = {root_reg[ch][mgr_pkg::PIX_W-2:0], 1'b0};
                    end
                    rad_next[ch] = {rad_reg[ch][mgr_pkg::RAD_W-3:0], 2'b00};
                end
                if (step_reg == '0)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    step_next = step_reg - mgr_pkg::STEP_W'(1);
                end
            end

            ST_WRITE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    for (int ch = 0; ch < mgr_pkg::NUM_CH; ch++)
                    begin
                        out_next[ch] = sat_reg[ch] ? '1 : root_reg[ch];
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        empty     = !out_valid_reg;
        red_out   = out_reg[0];
        green_out = out_reg[1];
        blue_out  = out_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            n_reg         <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            rad_reg       <= '0;
            srem_reg      <= '0;
            root_reg      <= '0;
            sat_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            n_reg         <= n_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            rad_reg       <= rad_next;
            srem_reg      <= srem_next;
            root_reg      <= root_next;
            sat_reg       <= sat_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/multisample_gamma_resolve_top.sv]
// Top level of the multisample gamma resolve block.
// Samples are accepted one per cycle whenever full is low; each is added into the per-pixel
// channel sums, and the sample that reaches samples_per_pixel (0 read as 1, values above
// MAX_SAMPLES read as MAX_SAMPLES) issues a pixel job into a four-entry queue. The back end
// resolves one pixel at a time: it takes the job, runs the bit-serial divide of twice the sum
// by the sample count, then the bit-serial square root, and then loads the result register,
// with all three channels in parallel. Full rises only when the job queue holds four pixels,
// so the input stalls only when the back end falls behind the pixel jobs and the queue fills.
// Results wait in the output register, which holds the back end while it is occupied, and are
// removed by pop while empty is low.
module multisample_gamma_resolve_top #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [mgr_pkg::SPP_W-1:0]     cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [mgr_pkg::SAMPLE_W-1:0]  red_sample,
    input  logic [mgr_pkg::SAMPLE_W-1:0]  green_sample,
    input  logic [mgr_pkg::SAMPLE_W-1:0]  blue_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic [mgr_pkg::PIX_W-1:0]     red_out,
    output logic [mgr_pkg::PIX_W-1:0]     green_out,
    output logic [mgr_pkg::PIX_W-1:0]     blue_out
);

    mgr_pkg::job_t job_in;
    mgr_pkg::job_t job_out;
    logic          job_push;
    logic          job_full;
    logic          job_pop;
    logic          job_empty;

    mgr_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .red_sample   (red_sample),
        .green_sample (green_sample),
        .blue_sample  (blue_sample),
        .job_full     (job_full),
        .job_push     (job_push),
        .job          (job_in)
    );

    mgr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (job_in),
        .full    (job_full),
        .pop     (job_pop),
        .job_out (job_out),
        .empty   (job_empty)
    );

    mgr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

[tb/tb_multisample_gamma_resolve_top.sv]
// Self-checking testbench for the multisample gamma resolve block with random stimulus.
`timescale 1ns / 1ps

module tb_multisample_gamma_resolve_top;

    localparam int SAMPLE_CAP    = 256;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic [mgr_pkg::SAMPLE_W-1:0] red;
        logic [mgr_pkg::SAMPLE_W-1:0] green;
        logic [mgr_pkg::SAMPLE_W-1:0] blue;
    } sample_t;

    typedef struct packed {
        logic [mgr_pkg::PIX_W-1:0] red;
        logic [mgr_pkg::PIX_W-1:0] green;
        logic [mgr_pkg::PIX_W-1:0] blue;
    } pixel_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         cfg_write    = 1'b0;
    logic [mgr_pkg::SPP_W-1:0]    cfg_data     = '0;
    logic                         push         = 1'b0;
    logic                         full;
    logic [mgr_pkg::SAMPLE_W-1:0] red_sample   = '0;
    logic [mgr_pkg::SAMPLE_W-1:0] green_sample = '0;
    logic [mgr_pkg::SAMPLE_W-1:0] blue_sample  = '0;
    logic                         empty;
    logic                         pop          = 1'b0;
    logic [mgr_pkg::PIX_W-1:0]    red_out;
    logic [mgr_pkg::PIX_W-1:0]    green_out;
    logic [mgr_pkg::PIX_W-1:0]    blue_out;

    sample_t          pending_samples[$];
    pixel_t           expected_pixels[$];
    sample_t          next_sample;

    logic [mgr_pkg::SPP_W-1:0] spp_setting = mgr_pkg::SPP_RESET;
    logic [mgr_pkg::SUM_W-1:0] red_acc     = '0;
    logic [mgr_pkg::SUM_W-1:0] green_acc   = '0;
    logic [mgr_pkg::SUM_W-1:0] blue_acc    = '0;
    int                        fill_count  = 0;

    int               mismatches  = 0;
    int               cycle_count = 0;
    int               push_gap    = 0;
    int               pop_gap     = 0;
    bit               push_burst  = 1'b0;
    bit               pop_burst   = 1'b0;

    multisample_gamma_resolve_top #(
        .MAX_SAMPLES(SAMPLE_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .red_sample(red_sample),
        .green_sample(green_sample),
        .blue_sample(blue_sample),
        .empty(empty),
        .pop(pop),
        .red_out(red_out),
        .green_out(green_out),
        .blue_out(blue_out)
    );

    always #10 clk = ~clk;

    function automatic logic [mgr_pkg::SUM_W-1:0] saturating_add(
        input logic [mgr_pkg::SUM_W-1:0]    acc,
        input logic [mgr_pkg::SAMPLE_W-1:0] value);
        logic [mgr_pkg::SUM_W:0] total;
        total = {1'b0, acc} + (mgr_pkg::SUM_W + 1)'(value);
        return total[mgr_pkg::SUM_W] ? {mgr_pkg::SUM_W{1'b1}} : total[mgr_pkg::SUM_W-1:0];
    endfunction

    function automatic logic [mgr_pkg::PIX_W-1:0] resolve_channel(
        input logic [mgr_pkg::SUM_W-1:0] total,
        input int                        divisor);
        int quotient;
        int root;
        int trial;
        quotient = (2 * int'(total)) / divisor;
        root = 0;
        for (int b = 12; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= quotient)
                root = trial;
        end
        return (root > 255) ? 8'd255 : root[mgr_pkg::PIX_W-1:0];
    endfunction

    task automatic absorb_sample(input sample_t s);
        int     divisor;
        pixel_t pix;
        divisor = int'(spp_setting);
        if (divisor < 1)
            divisor = 1;
        if (divisor > SAMPLE_CAP)
            divisor = SAMPLE_CAP;
        red_acc   = saturating_add(red_acc, s.red);
        green_acc = saturating_add(green_acc, s.green);
        blue_acc  = saturating_add(blue_acc, s.blue);
        fill_count++;
        if (fill_count >= divisor)
        begin
            pix.red   = resolve_channel(red_acc, divisor);
            pix.green = resolve_channel(green_acc, divisor);
            pix.blue  = resolve_channel(blue_acc, divisor);
            expected_pixels.push_back(pix);
            red_acc    = '0;
            green_acc  = '0;
            blue_acc   = '0;
            fill_count = 0;
        end
    endtask

    task automatic compare_channel(input string label, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    task automatic check_pixel(input pixel_t got);
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            $display("%0t: pixel transfer with none expected, actual %0d %0d %0d",
                     $time, got.red, got.green, got.blue);
        end
        else
        begin
            want = expected_pixels.pop_front();
            compare_channel("red", int'(want.red), int'(got.red));
            compare_channel("green", int'(want.green), int'(got.green));
            compare_channel("blue", int'(want.blue), int'(got.blue));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            push_gap = 0;
        end
        else
        begin
            if (push && !full)
                absorb_sample({red_sample, green_sample, blue_sample});
            if (!push || !full)
            begin
                if (push_gap != 0)
                begin
                    push <= 1'b0;
                    push_gap--;
                end
                else if (pending_samples.size() != 0)
                begin
                    next_sample = pending_samples.pop_front();
                    red_sample   <= next_sample.red;
                    green_sample <= next_sample.green;
                    blue_sample  <= next_sample.blue;
                    push <= 1'b1;
                    if ($urandom_range(0, 23) == 0)
                        push_burst = !push_burst;
                    push_gap = push_burst ? 0 : $urandom_range(0, 8);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_gap = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_pixel({red_out, green_out, blue_out});
                if ($urandom_range(0, 23) == 0)
                    pop_burst = !pop_burst;
                pop_gap = pop_burst ? 0 : $urandom_range(0, 8);
            end
            if (pop_gap == 0)
            begin
                pop <= 1'b1;
            end
            else
            begin
                pop <= 1'b0;
                pop_gap--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic settle();
        while (pending_samples.size() != 0 || push)
            @(negedge clk);
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_spp(input logic [mgr_pkg::SPP_W-1:0] value);
        settle();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        spp_setting = value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_sample(input int r, input int g, input int b);
        sample_t s;
        s.red   = r[mgr_pkg::SAMPLE_W-1:0];
        s.green = g[mgr_pkg::SAMPLE_W-1:0];
        s.blue  = b[mgr_pkg::SAMPLE_W-1:0];
        pending_samples.push_back(s);
    endtask

    function automatic int random_channel();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 32768;
            2:       return $urandom_range(0, 65535);
            3:       return $urandom_range(32769, 65535);
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_sample(random_channel(), random_channel(), random_channel());
    endtask

    initial
    begin
        int settings[10];
        settings = '{2, 1, 7, 0, 35, 3, 60, 4, 0, 36};
        settings[8] = $urandom_range(1, 40);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // The reset value of five samples per pixel is in effect here.
        repeat (5) queue_sample(0, 0, 0);
        repeat (5) queue_sample(32768, 32768, 32768);
        repeat (5) queue_sample(65535, 0, 16384);

        write_spp(9'd1);
        queue_sample(1, 16'hAAAA, 16'h5555);
        queue_sample(16384, 32767, 128);
        queue_sample(65535, 65535, 65535);
        queue_sample(0, 32768, 1);

        write_spp(9'd0);
        queue_sample(32768, 0, 256);
        queue_sample(255, 4096, 1024);

        // A smaller count written mid-pixel makes the next sample complete it.
        write_spp(9'd3);
        queue_sample(30000, 20000, 10000);
        queue_sample(30000, 20000, 10000);
        write_spp(9'd2);
        queue_sample(5000, 5000, 5000);

        foreach (settings[i])
        begin
            write_spp(settings[i][mgr_pkg::SPP_W-1:0]);
            queue_random($urandom_range(15, 40));
        end

        write_spp(9'd511);
        queue_random(130);
        write_spp(9'd256);
        queue_random(140);

        settle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
